// ----- src/tlc_pkg.sv -----
// Package for the lifetime lookup cache: sizes, entry layout, opcodes, FSM states.
// No dependencies.
`default_nettype none
package tlc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 24;
  localparam int TIME_W  = 32;

  localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd21600000;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key_addr;
    logic [TIME_W-1:0] stamp;
    logic              flag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- src/tlc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/ttl_lookup_cache_oldest_replace.sv -----
// Fully associative lookup cache with entry lifetime and oldest-entry replacement.
// Depends on tlc_pkg and tlc_ram.
// Lookup: a serial scan of the entry RAM, one read per cycle, then the result.
// Store into a free entry: a direct write; store into a full cache: a scan for the
//   oldest stamp, then a write.
// One item at a time; the next item is taken while the result beat waits.
// Synchronous active-low reset clears valid bits, FSM and output valid, and loads
//   the default lifetime.
`default_nettype none
module ttl_lookup_cache_oldest_replace
  import tlc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [KEY_W-1:0]  in_key_address,
  input  wire logic [TIME_W-1:0] in_now_ms,
  input  wire logic              in_flag_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic                   out_flag_out
);

  state_t             state_r, state_nxt;
  logic [TIME_W-1:0]  lifetime_r;
  logic [ENTRIES-1:0] valid_r;

  logic               op_r;
  logic [KEY_W-1:0]   key_r;
  logic [TIME_W-1:0]  now_r;
  logic               flag_r;
  logic [CNT_W-1:0]   addr_r;
  logic               chk_vld_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               found_r;
  logic               hit_r;
  logic               fout_r;
  logic [IDX_W-1:0]   slot_r;
  logic [TIME_W-1:0]  min_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic               out_flag_r;

  logic               accept;
  logic               issue;
  logic               scan_end;
  logic               load_out;
  logic               ram_we;
  logic               has_free;
  logic [IDX_W-1:0]   free_idx;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_ent;
  entry_t             wr_ent;
  logic [TIME_W-1:0]  age;
  logic               key_match;

  tlc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (wr_ent),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign rd_ent    = entry_t'(rd_data);
  assign wr_ent    = '{key_addr: key_r, stamp: now_r, flag: flag_r};
  assign age       = now_r - rd_ent.stamp;
  assign key_match = valid_r[chk_idx_r] && (rd_ent.key_addr == key_r);
  assign scan_end  = (addr_r == CNT_W'(ENTRIES));

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_STORE && has_free) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = (op_r == OP_STORE) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  issue    = !scan_end;
      ST_WRITE: ram_we   = 1'b1;
      ST_DONE:  load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lifetime_r  <= LIFETIME_RESET;
      valid_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= issue;
      out_valid_r <= load_out || (out_valid_r && !out_ready);
      if (cfg_we) begin
        lifetime_r <= cfg_wdata;
      end
      if (ram_we) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= addr_r[IDX_W-1:0];
    if (accept) begin
      op_r    <= in_opcode;
      key_r   <= in_key_address;
      now_r   <= in_now_ms;
      flag_r  <= in_flag_in;
      addr_r  <= '0;
      found_r <= 1'b0;
      hit_r   <= 1'b0;
      fout_r  <= 1'b0;
      slot_r  <= free_idx;
      min_r   <= '0;
    end else begin
      if (issue) begin
        addr_r <= addr_r + CNT_W'(1);
      end
      if (chk_vld_r) begin
        if (op_r == OP_LOOKUP) begin
          if (!found_r && key_match) begin
            found_r <= 1'b1;
            hit_r   <= (age < lifetime_r);
            fout_r  <= (age < lifetime_r) && rd_ent.flag;
          end
        end else if (chk_idx_r == '0 || rd_ent.stamp < min_r) begin
          min_r  <= rd_ent.stamp;
          slot_r <= chk_idx_r;
        end
      end
    end
    if (load_out) begin
      out_hit_r  <= hit_r;
      out_flag_r <= fout_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_flag_out = out_flag_r;

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(slot_r)])
    else $error("written entry not marked valid");

  a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(valid_r) >= $countones($past(valid_r)))
    else $error("valid entry lost without reset");

  a_store_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && op_r == OP_STORE) |-> (!hit_r && !fout_r))
    else $error("store reports a hit");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule
`default_nettype wire

// ----- verif/ttl_lookup_cache_oldest_replace_tb.sv -----
// Testbench for ttl_lookup_cache_oldest_replace: a directed table, then random lookup/store
// traffic over several lifetime settings, checked beat by beat against a cache predictor.
// Depends on tlc_pkg and the cache RTL.
`timescale 1ns / 1ps
module ttl_lookup_cache_oldest_replace_tb;
  import tlc_pkg::*;

  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              flag;
  } cache_req_t;

  typedef struct packed {
    logic hit;
    logic flag;
  } cache_resp_t;

  typedef struct packed {
    cache_req_t  req;
    logic        typed;
    cache_resp_t resp;
  } dir_row_t;

  localparam int DIR_N    = 14;
  localparam int PHASES   = 6;
  localparam int PHASE_N  = 306;
  localparam int POOL_N   = 10;
  localparam int IDLE_PCT = 35;

  localparam logic [TIME_W-1:0] PHASE_LIFE [PHASES] = '{
    32'd1000, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd50000, LIFETIME_RESET
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = OP_LOOKUP;
  logic [KEY_W-1:0]  in_key_address = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic              in_flag_in = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic              out_flag_out;

  ttl_lookup_cache_oldest_replace DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_key_address (in_key_address),
    .in_now_ms      (in_now_ms),
    .in_flag_in     (in_flag_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_flag_out   (out_flag_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  logic              model_valid [ENTRIES];
  entry_t            model_entry [ENTRIES];
  logic [TIME_W-1:0] model_lifetime;

  cache_resp_t pending_resp[$];
  bit          idle_on = 1'b1;
  int          errors = 0;
  int          beats_sent = 0;
  int          lookups_sent = 0;
  int          hits_seen = 0;

  function automatic cache_resp_t cache_predict(cache_req_t req);
    cache_resp_t       resp;
    int                slot;
    logic [TIME_W-1:0] age;
    bit                found;
    resp  = '0;
    found = 1'b0;
    slot  = -1;
    if (req.opcode == OP_LOOKUP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && model_valid[i] && model_entry[i].key_addr == req.key) begin
          found = 1'b1;
          age   = req.now - model_entry[i].stamp;
          if (age < model_lifetime) begin
            resp.hit  = 1'b1;
            resp.flag = model_entry[i].flag;
          end
        end
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !model_valid[i]) slot = i;
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < ENTRIES; i++)
          if (model_entry[i].stamp < model_entry[slot].stamp) slot = i;
      end
      model_valid[slot] = 1'b1;
      model_entry[slot] = '{key_addr: req.key, stamp: req.now, flag: req.flag};
    end
    return resp;
  endfunction

  task automatic send_beat(input cache_req_t req, input logic typed, input cache_resp_t want);
    cache_resp_t resp;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid       <= 1'b1;
    in_opcode      <= req.opcode;
    in_key_address <= req.key;
    in_now_ms      <= req.now;
    in_flag_in     <= req.flag;
    do @(posedge clk); while (!in_ready);
    resp = cache_predict(req);
    if (typed) resp = want;
    pending_resp.push_back(resp);
    beats_sent++;
    if (req.opcode == OP_LOOKUP) lookups_sent++;
    if (resp.hit) hits_seen++;
  endtask

  task automatic write_lifetime(input logic [TIME_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    model_lifetime = value;
  endtask

  always @(posedge clk) begin : result_side
    cache_resp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        $error("result beat with no lookup or store outstanding");
        errors++;
      end else begin
        want = pending_resp.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_hit);
          errors++;
        end
        if (out_flag_out !== want.flag) begin
          $error("flag_out: expected %0b, got %0b", want.flag, out_flag_out);
          errors++;
        end
      end
    end
    out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin : stimulus
    dir_row_t          dir_rows [DIR_N];
    logic [KEY_W-1:0]  key_pool [POOL_N];
    logic [TIME_W-1:0] t_now;
    logic [TIME_W-1:0] span;
    cache_req_t        req;
    int                roll;

    dir_rows = '{
      '{'{OP_LOOKUP, 24'h000000, 32'h0000_0000, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_STORE,  24'hFFFFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_STORE,  24'h000000, 32'h0000_0000, 1'b0}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_LOOKUP, 24'hFFFFFF, 32'h0000_0010, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_LOOKUP, 24'h000000, 32'd21599999,  1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_LOOKUP, 24'h000000, 32'd21600000,  1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_STORE,  24'hABCDEF, 32'd100,       1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_STORE,  24'hABCDEF, 32'd30000000,  1'b0}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_LOOKUP, 24'hABCDEF, 32'd30000001,  1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_STORE,  24'h5A5A5A, 32'h8000_0000, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_LOOKUP, 24'h5A5A5A, 32'h8000_0000, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_LOOKUP, 24'h123456, 32'h5555_5555, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_STORE,  24'h000000, 32'h7FFF_FFFF, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_LOOKUP, 24'h000000, 32'h7FFF_FFFF, 1'b0}, 1'b0, '{1'b0, 1'b0}}
    };

    model_lifetime = LIFETIME_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      model_valid[i] = 1'b0;
      model_entry[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      send_beat(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].resp);

    for (int p = 0; p < PHASES; p++) begin
      write_lifetime(PHASE_LIFE[p]);
      idle_on = (p != 3);
      t_now   = (p == 0) ? 32'hFFFF_FC00 : TIME_W'($urandom);
      if (PHASE_LIFE[p] <= 2)
        span = 1;
      else if (PHASE_LIFE[p] == '1)
        span = 32'h0100_0000;
      else
        span = PHASE_LIFE[p] / 6 + 1;
      foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
      key_pool[0] = '0;
      key_pool[1] = '1;

      for (int n = 0; n < PHASE_N; n++) begin
        req.opcode = ($urandom_range(0, 99) < 40) ? OP_STORE : OP_LOOKUP;
        req.key    = ($urandom_range(0, 99) < 5) ? KEY_W'($urandom)
                                                 : key_pool[$urandom_range(0, POOL_N - 1)];
        req.flag   = 1'($urandom_range(0, 1));
        roll       = $urandom_range(0, 99);
        if (roll < 3) begin
          req.now = TIME_W'($urandom);
        end else begin
          if (roll >= 30) t_now = t_now + TIME_W'($urandom_range(0, span));
          req.now = t_now;
        end
        send_beat(req, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    idle_on  = 1'b1;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Sent %0d beats (%0d lookups, %0d expected hits) over %0d lifetime settings,",
             beats_sent, lookups_sent, hits_seen, PHASES + 1);
    $display("including zero, one and all-ones lifetimes and time wrap.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
